[rtl/gpt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package gpt_pkg;
   localparam int IDX_W      = 16;
   localparam int POS_W      = 34;
   localparam int TEX_W      = 17;
   localparam int FRAC_W     = 16;
   localparam int CFG_GRID_W = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic OP_VERTEX = 1'b0;
   localparam logic OP_QUAD   = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_COLS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_ROWS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_EXTENT_X  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_EXTENT_Y  = 3'd5;

   typedef struct packed {
      logic             opcode;
      logic [IDX_W-1:0] item_index;
      logic             in_range;
   } cmd_type;

   typedef struct packed {
      logic                    valid_res;
      logic signed [POS_W-1:0] vert_x;
      logic signed [POS_W-1:0] vert_y;
      logic [TEX_W-1:0]        tex_u;
      logic [TEX_W-1:0]        tex_v;
      logic [IDX_W-1:0]        tri_a;
      logic [IDX_W-1:0]        tri_b;
      logic [IDX_W-1:0]        tri_c;
      logic                    last;
   } res_type;
endpackage
`default_nettype wire

[rtl/gpt_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
module gpt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] din,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      dout,
   output logic                  empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) mem_ff[wr_ff] <= din;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH)) else $error("fifo count overflow");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("fifo count did not grow on push");
   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> cnt_ff == $past(cnt_ff) - 1'b1)
      else $error("fifo count did not shrink on pop");
endmodule
`default_nettype wire

[rtl/gpt_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module gpt_div #(
   parameter int NW = 16,
   parameter int DW = 9
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic [NW-1:0]      quo,
   output logic [DW-1:0]      rem,
   output logic               done
);
   localparam int CW = $clog2(NW);

   logic [DW-1:0] acc_ff, acc_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [DW:0]   trial, diff;
   logic          fits;

   // one quotient bit per cycle, restoring
   assign trial = {acc_ff, quo_ff[NW-1]};
   assign fits  = (trial >= {1'b0, den});
   assign diff  = trial - {1'b0, den};

   always_comb begin
      acc_in  = acc_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         quo_in  = num;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = fits ? diff[DW-1:0] : trial[DW-1:0];
         quo_in = {quo_ff[NW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      quo_ff <= quo_in;
   end

   assign quo  = quo_ff;
   assign rem  = acc_ff;
   assign done = done_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff) else $error("done without run");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider restarted while busy");
   a_rem_small: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> acc_ff < den) else $error("remainder not below divisor");
endmodule
`default_nettype wire

[rtl/gpt_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module gpt_front #(
   parameter int GW = 9
) (
   input  wire logic                      req_opcode,
   input  wire logic [gpt_pkg::IDX_W-1:0] req_item_index,
   input  wire logic [GW-1:0]             cols,
   input  wire logic [GW-1:0]             rows,
   output gpt_pkg::cmd_type               cmd
);
   import gpt_pkg::*;

   logic [2*GW-1:0] n_vert, n_quad, limit;

   // classify: range check against vertex or quad count
   assign n_vert = cols * rows;
   assign n_quad = (cols - 1'b1) * (rows - 1'b1);
   assign limit  = (req_opcode == OP_QUAD) ? n_quad : n_vert;

   always_comb begin
      cmd.opcode     = req_opcode;
      cmd.item_index = req_item_index;
      if (2 * GW >= IDX_W)
         cmd.in_range = (((2 * GW + 1))'(req_item_index) < ((2 * GW + 1))'(limit));
      else
         cmd.in_range = ((IDX_W + 1)'(req_item_index) < (IDX_W + 1)'(limit));
   end
endmodule
`default_nettype wire

[rtl/gpt_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module gpt_back #(
   parameter int GW = 9
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [GW-1:0]                  cols,
   input  wire logic [GW-1:0]                  rows,
   input  wire logic [gpt_pkg::CSR_DATA_W-1:0] origin_x,
   input  wire logic [gpt_pkg::CSR_DATA_W-1:0] origin_y,
   input  wire logic [gpt_pkg::CSR_DATA_W-1:0] extent_x,
   input  wire logic [gpt_pkg::CSR_DATA_W-1:0] extent_y,
   input  wire gpt_pkg::cmd_type               cmd,
   input  wire logic                           cmd_empty,
   output logic                                cmd_pop,
   output gpt_pkg::res_type                    res,
   input  wire logic                           res_full,
   output logic                                res_push
);
   import gpt_pkg::*;

   localparam int PW = GW + CSR_DATA_W;
   localparam int XW = PW + FRAC_W;
   localparam int UW = GW + FRAC_W;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_DIVI  = 7'b0000010,
      ST_MUL   = 7'b0000100,
      ST_LOADP = 7'b0001000,
      ST_WAITP = 7'b0010000,
      ST_EMIT0 = 7'b0100000,
      ST_EMIT1 = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic             op_ff, ok_ff;
   logic [GW-1:0]    cs, rs, den_i;
   logic [GW-1:0]    col_ff, row_ff;
   logic [PW-1:0]    px_ff, py_ff;
   logic [IDX_W-1:0] lt_ff;
   logic [IDX_W-1:0] qi;
   logic [GW-1:0]    ri;
   logic             di_done, dx_done;
   logic             start_i, start_p;
   logic [XW-1:0]    qx, qy;
   logic [UW-1:0]    qu, qv;
   logic [GW-1:0]    unused_rx, unused_ry, unused_ru, unused_rv;
   logic             unused_dy, unused_du, unused_dv;
   logic [IDX_W-1:0] lb, rt;
   logic [POS_W-1:0] base_x, base_y;

   assign cs    = cols - 1'b1;
   assign rs    = rows - 1'b1;
   assign den_i = (op_ff == OP_QUAD) ? cs : cols;

   assign cmd_pop = (state_ff == ST_IDLE) && !cmd_empty;
   assign start_i = cmd_pop && cmd.in_range;
   assign start_p = (state_ff == ST_LOADP);

   gpt_div #(.NW(IDX_W), .DW(GW)) u_div_idx (
      .clock, .reset, .start(start_i), .num(cmd.item_index), .den(den_i),
      .quo(qi), .rem(ri), .done(di_done));
   gpt_div #(.NW(XW), .DW(GW)) u_div_x (
      .clock, .reset, .start(start_p), .num({px_ff, FRAC_W'(0)}), .den(cs),
      .quo(qx), .rem(unused_rx), .done(dx_done));
   gpt_div #(.NW(XW), .DW(GW)) u_div_y (
      .clock, .reset, .start(start_p), .num({py_ff, FRAC_W'(0)}), .den(rs),
      .quo(qy), .rem(unused_ry), .done(unused_dy));
   gpt_div #(.NW(UW), .DW(GW)) u_div_u (
      .clock, .reset, .start(start_p), .num({col_ff, FRAC_W'(0)}), .den(cs),
      .quo(qu), .rem(unused_ru), .done(unused_du));
   gpt_div #(.NW(UW), .DW(GW)) u_div_v (
      .clock, .reset, .start(start_p), .num({row_ff, FRAC_W'(0)}), .den(rs),
      .quo(qv), .rem(unused_rv), .done(unused_dv));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (!cmd_empty) state_in = cmd.in_range ? ST_DIVI : ST_EMIT1;
         ST_DIVI:  if (di_done) state_in = ST_MUL;
         ST_MUL:   state_in = (op_ff == OP_QUAD) ? ST_EMIT0 : ST_LOADP;
         ST_LOADP: state_in = ST_WAITP;
         ST_WAITP: if (dx_done) state_in = ST_EMIT1;
         ST_EMIT0: if (!res_full) state_in = ST_EMIT1;
         ST_EMIT1: if (!res_full) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
      if (cmd_pop) begin
         op_ff <= cmd.opcode;
         ok_ff <= cmd.in_range;
      end
      if (state_ff == ST_DIVI && di_done) begin
         col_ff <= ri;
         row_ff <= qi[GW-1:0];
      end
      if (state_ff == ST_MUL) begin
         px_ff <= col_ff * extent_x;
         py_ff <= row_ff * extent_y;
      end
      // quad corner: quad row times column count plus quad column
      if (state_ff == ST_DIVI && di_done)
         lt_ff <= IDX_W'(qi * cols + IDX_W'(ri));
   end

   assign rt     = lt_ff + 1'b1;
   assign lb     = lt_ff + IDX_W'(cols);
   assign base_x = {{(POS_W-CSR_DATA_W-FRAC_W){origin_x[CSR_DATA_W-1]}}, origin_x,
                    FRAC_W'(0)};
   assign base_y = {{(POS_W-CSR_DATA_W-FRAC_W){origin_y[CSR_DATA_W-1]}}, origin_y,
                    FRAC_W'(0)};

   always_comb begin
      res = '0;
      res.last = (state_ff == ST_EMIT1);
      if (state_ff == ST_EMIT0) begin
         res.valid_res = 1'b1;
         res.tri_a     = lt_ff;
         res.tri_b     = rt;
         res.tri_c     = lb;
      end else if (ok_ff && op_ff == OP_QUAD) begin
         res.valid_res = 1'b1;
         res.tri_a     = lb;
         res.tri_b     = rt;
         res.tri_c     = lb + 1'b1;
      end else if (ok_ff) begin
         res.valid_res = 1'b1;
         res.vert_x    = base_x + POS_W'(qx[2*FRAC_W-1:0]);
         res.vert_y    = base_y + POS_W'(qy[2*FRAC_W-1:0]);
         res.tex_u     = qu[TEX_W-1:0];
         res.tex_v     = qv[TEX_W-1:0];
      end
   end

   assign res_push = (state_ff == ST_EMIT0 || state_ff == ST_EMIT1) && !res_full;

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> state_ff != ST_IDLE) else $error("pop did not start work");
   a_first_tri: assert property (@(posedge clock) disable iff (reset)
      (res_push && !res.last) |=> state_ff == ST_EMIT1)
      else $error("first triangle not followed by second");
   a_range_path: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && !cmd.in_range) |=> state_ff == ST_EMIT1)
      else $error("out of range item took divide path");
endmodule
`default_nettype wire

[rtl/grid_plane_tessellator_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// grid plane tessellator
// input queue: drive req_opcode / req_item_index and raise req_push; the item
// transfers on a clock edge with req_push high and req_full low.
// result queue: while rsp_empty is low the oldest result is on the rsp_ ports;
// raise rsp_pop to transfer it. a quad request yields two results (last low,
// then last high); a vertex request or an out-of-range index yields one.
// csr_we writes csr_wdata into register csr_index at the clock edge; write
// only while no transfer is outstanding.
// timing: a two-entry command queue sits in front of the sequencer, so items
// are taken while earlier ones are in work. an in-range item runs a serial
// index divide; a vertex then runs position and texture divides, one
// quotient bit a cycle. those serial dividers set the rate, and the
// command and result queues add to the latency. when rsp_pop is held low
// the result queue fills, the sequencer waits, then the command queue fills
// and req_full rises; nothing is dropped.
// reset: queues empty, cols and rows 2, origin and extent 0.
module grid_plane_tessellator_core #(
   parameter int GRID_MAX = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic                           req_opcode,
   input  wire logic [gpt_pkg::IDX_W-1:0]      req_item_index,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic                                rsp_valid_res,
   output logic signed [gpt_pkg::POS_W-1:0]    rsp_vert_x,
   output logic signed [gpt_pkg::POS_W-1:0]    rsp_vert_y,
   output logic [gpt_pkg::TEX_W-1:0]           rsp_tex_u,
   output logic [gpt_pkg::TEX_W-1:0]           rsp_tex_v,
   output logic [gpt_pkg::IDX_W-1:0]           rsp_tri_a,
   output logic [gpt_pkg::IDX_W-1:0]           rsp_tri_b,
   output logic [gpt_pkg::IDX_W-1:0]           rsp_tri_c,
   output logic                                rsp_last,
   input  wire logic                           csr_we,
   input  wire logic [gpt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [gpt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import gpt_pkg::*;

   localparam int GW = $clog2(GRID_MAX + 1);

   logic [CFG_GRID_W-1:0] cols_ff, rows_ff;
   logic [CSR_DATA_W-1:0] org_x_ff, org_y_ff, ext_x_ff, ext_y_ff;
   logic [GW-1:0]         cols, rows;
   cmd_type               cmd_front, cmd_back;
   logic                  cmd_empty, cmd_pop;
   res_type               res_back, res_out;
   logic                  res_full, res_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= CFG_GRID_W'(2);
         rows_ff  <= CFG_GRID_W'(2);
         org_x_ff <= '0;
         org_y_ff <= '0;
         ext_x_ff <= '0;
         ext_y_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_GRID_COLS: cols_ff  <= csr_wdata[CFG_GRID_W-1:0];
            REG_GRID_ROWS: rows_ff  <= csr_wdata[CFG_GRID_W-1:0];
            REG_ORIGIN_X:  org_x_ff <= csr_wdata;
            REG_ORIGIN_Y:  org_y_ff <= csr_wdata;
            REG_EXTENT_X:  ext_x_ff <= csr_wdata;
            REG_EXTENT_Y:  ext_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // grid size clamped to 2..GRID_MAX
   always_comb begin
      if (cols_ff < CFG_GRID_W'(2))           cols = GW'(2);
      else if (int'(cols_ff) > GRID_MAX)      cols = GW'(GRID_MAX);
      else                                    cols = GW'(cols_ff);
      if (rows_ff < CFG_GRID_W'(2))           rows = GW'(2);
      else if (int'(rows_ff) > GRID_MAX)      rows = GW'(GRID_MAX);
      else                                    rows = GW'(rows_ff);
   end

   gpt_front #(.GW(GW)) u_front (
      .req_opcode, .req_item_index, .cols, .rows, .cmd(cmd_front));

   gpt_fifo #(.WIDTH($bits(cmd_type)), .DEPTH(2)) u_cmd_q (
      .clock, .reset, .push(req_push), .din(cmd_front), .full(req_full),
      .pop(cmd_pop), .dout(cmd_back), .empty(cmd_empty));

   gpt_back #(.GW(GW)) u_back (
      .clock, .reset, .cols, .rows,
      .origin_x(org_x_ff), .origin_y(org_y_ff),
      .extent_x(ext_x_ff), .extent_y(ext_y_ff),
      .cmd(cmd_back), .cmd_empty, .cmd_pop,
      .res(res_back), .res_full, .res_push);

   gpt_fifo #(.WIDTH($bits(res_type)), .DEPTH(2)) u_res_q (
      .clock, .reset, .push(res_push), .din(res_back), .full(res_full),
      .pop(rsp_pop), .dout(res_out), .empty(rsp_empty));

   assign rsp_valid_res = res_out.valid_res;
   assign rsp_vert_x    = res_out.vert_x;
   assign rsp_vert_y    = res_out.vert_y;
   assign rsp_tex_u     = res_out.tex_u;
   assign rsp_tex_v     = res_out.tex_v;
   assign rsp_tri_a     = res_out.tri_a;
   assign rsp_tri_b     = res_out.tri_b;
   assign rsp_tri_c     = res_out.tri_c;
   assign rsp_last      = res_out.last;
endmodule
`default_nettype wire
